// ===== rtl/core/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

    // One map word covers this many blocks
    localparam int WORD_W  = 8;
    localparam int BIT_W   = 3;
    localparam int RES_W   = 9;
    localparam int BLK_W   = 8;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2
    } t_op;

endpackage

`default_nettype wire

// ===== rtl/core/bba_map_ram.sv =====
`default_nettype none

module bba_map_ram import bba_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_word         i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_word              o_rdata
);

    t_word r_mem [DEPTH];
    t_word r_rdata;

    // read returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_block_allocator.sv =====
// Operation: allocate is first fit, one map word of 8 blocks read per cycle, and fails without
//   a scan when the pool is full; free reads and rewrites one word; initialize writes one
//   word per cycle; an unused operation code only returns a result; WORDS = NUM_BLOCKS/8, rounded up.
// Flow: one beat at a time, the next taken the cycle after the result is registered;
//   a stalled result holds the next request in S_DONE.
// Reset: synchronous, active low; a clearing pass over all WORDS words zeroes the map, no request taken.
`default_nettype none

module bitmap_block_allocator import bba_pkg::*; #(
    parameter int NUM_BLOCKS = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // request channel
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [1:0]       i_in_operation,
    input  wire logic [BLK_W-1:0] i_in_block_number,
    // result channel
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [BLK_W-1:0]      o_granted_block,
    output logic                  o_alloc_failed,
    output logic [RES_W-1:0]      o_free_count,
    // configuration: reserved block count
    input  wire logic             i_cfg_we,
    input  wire logic [RES_W-1:0] i_cfg_data
);

    localparam int WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_FREE  = 7'b0001000,
        S_INIT  = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_SPARE = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_scan_addr, n_scan_addr;   // word address being read
    logic [AW-1:0]     r_chk_addr, n_chk_addr;     // word whose data is on the read port
    logic [AW-1:0]     r_wr_addr, n_wr_addr;       // init sweep / free target word
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [CW-1:0]     r_used, n_used;             // blocks marked used by the sweep
    logic [CW-1:0]     r_free, n_free;
    logic [RES_W-1:0]  r_reserved;
    logic [BLK_W-1:0]  r_p_granted, n_p_granted;
    logic              r_p_failed, n_p_failed;
    logic              r_ov;
    logic [BLK_W-1:0]  r_o_granted;
    logic              r_o_failed;
    logic [RES_W-1:0]  r_o_count;

    // map memory port
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_word             mem_wdata;
    logic [AW-1:0]     mem_raddr;
    t_word             mem_rdata;

    logic [31:0]       blk_wide;
    logic              blk_in_pool;
    logic [AW-1:0]     blk_addr;
    logic [CW-1:0]     used_sat;
    t_word             init_word;
    t_word             pool_mask;
    t_word             scan_word;
    logic [BIT_W-1:0]  zero_idx;
    logic [31:0]       grant_wide;
    logic [31:0]       count_wide;
    logic              out_free;

    bba_map_ram #(
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // free request decode: block number split into word address and bit
    assign blk_wide    = 32'(i_in_block_number);
    assign blk_in_pool = blk_wide < 32'(NUM_BLOCKS);
    assign blk_addr    = blk_wide[AW+2:3];

    // initialize saturates at the pool size
    assign used_sat = (32'(r_reserved) > 32'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                          : CW'(r_reserved);

    // word written by the init/clear sweep, and pool mask for the word under check;
    // bits past the pool end read as used so the scan never grants them
    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            init_word[i] = 32'({r_wr_addr, BIT_W'(i)}) < 32'(r_used);
            pool_mask[i] = 32'({r_chk_addr, BIT_W'(i)}) < 32'(NUM_BLOCKS);
        end
    end

    assign scan_word = mem_rdata | ~pool_mask;

    // lowest clear bit of the word under check
    always_comb begin
        zero_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!scan_word[i]) begin
                zero_idx = BIT_W'(i);
            end
        end
    end

    assign grant_wide = 32'({r_chk_addr, zero_idx});
    assign count_wide = 32'(r_free);
    assign out_free   = !r_ov || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_scan_addr = r_scan_addr;
        n_chk_addr  = r_chk_addr;
        n_wr_addr   = r_wr_addr;
        n_bit       = r_bit;
        n_used      = r_used;
        n_free      = r_free;
        n_p_granted = r_p_granted;
        n_p_failed  = r_p_failed;
        mem_we      = 1'b0;
        mem_waddr   = r_wr_addr;
        mem_wdata   = init_word;
        mem_raddr   = r_scan_addr;
        o_in_ready  = 1'b0;

        case (r_state)
            S_CLEAR, S_INIT: begin
                // one word per cycle; reset leaves r_used at zero
                mem_we = 1'b1;
                if (r_wr_addr == AW'(WORDS - 1)) begin
                    n_free  = CW'(NUM_BLOCKS) - r_used;
                    n_state = (r_state == S_INIT) ? S_DONE : S_IDLE;
                end else begin
                    n_wr_addr = r_wr_addr + AW'(1);
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_p_granted = '0;
                    n_p_failed  = 1'b0;
                    case (t_op'(i_in_operation))
                        OP_ALLOC: begin
                            if (r_free == '0) begin
                                // pool full: fail without touching the map
                                n_p_failed = 1'b1;
                                n_state    = S_DONE;
                            end else begin
                                mem_raddr   = '0;
                                n_chk_addr  = '0;
                                n_scan_addr = AW'(1);
                                n_state     = S_SCAN;
                            end
                        end
                        OP_FREE: begin
                            if (blk_in_pool) begin
                                mem_raddr = blk_addr;
                                n_wr_addr = blk_addr;
                                n_bit     = i_in_block_number[BIT_W-1:0];
                                n_state   = S_FREE;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        OP_INIT: begin
                            n_used    = used_sat;
                            n_wr_addr = '0;
                            n_state   = S_INIT;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read of the next word overlaps the check of this one; a free
                // block is known to exist, so the scan always ends in a grant
                n_chk_addr  = r_scan_addr;
                n_scan_addr = r_scan_addr + AW'(1);
                if (scan_word != '1) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_chk_addr;
                    mem_wdata   = mem_rdata | (t_word'(1) << zero_idx);
                    n_p_granted = grant_wide[BLK_W-1:0];
                    n_free      = r_free - CW'(1);
                    n_state     = S_DONE;
                end
            end
            S_FREE: begin
                // already-free block: nothing written
                if (mem_rdata[r_bit]) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata & ~(t_word'(1) << r_bit);
                    n_free    = r_free + CW'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_wr_addr   <= '0;
            r_used      <= '0;
            r_free      <= CW'(NUM_BLOCKS);
            r_reserved  <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_addr   <= n_wr_addr;
            r_used      <= n_used;
            r_free      <= n_free;
            if (i_cfg_we) begin
                r_reserved <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_scan_addr <= n_scan_addr;
        r_chk_addr  <= n_chk_addr;
        r_bit       <= n_bit;
        r_p_granted <= n_p_granted;
        r_p_failed  <= n_p_failed;
        if (r_state == S_DONE && out_free) begin
            r_o_granted <= r_p_granted;
            r_o_failed  <= r_p_failed;
            r_o_count   <= count_wide[RES_W-1:0];
        end
    end

    assign o_out_valid     = r_ov;
    assign o_granted_block = r_o_granted;
    assign o_alloc_failed  = r_o_failed;
    assign o_free_count    = r_o_count;

    // free count never exceeds the pool
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= 32'(NUM_BLOCKS))
        else $error("free count above pool size");

    // a scan only runs while some block is free
    a_scan_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_free != '0))
        else $error("scan started with a full pool");

    // a failed allocate grants block zero
    a_fail_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alloc_failed) |-> (o_granted_block == '0))
        else $error("failed allocate with non-zero grant");

    // a successful scan takes exactly one block
    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_DONE) |=> (r_free == $past(r_free) - CW'(1)))
        else $error("grant did not take one block");

endmodule

`default_nettype wire
